>>> sv/fplc_pkg.sv
package fplc_pkg;

    // Default timer rate
    localparam int TICKS_PER_SECOND_DEFAULT = 4000000;

    // Configuration register indexes
    localparam logic CFG_LEAN_PRESSURE = 1'b0;
    localparam logic CFG_LEAN_LAMBDA   = 1'b1;

    // Configuration reset values
    localparam logic [11:0] LEAN_PRESSURE_RESET = 12'd1500;
    localparam logic [11:0] LEAN_LAMBDA_RESET   = 12'd850;

    // Stream widths
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 8;

    // Lamp levels, ordered by priority
    typedef enum logic [1:0] {
        LAMP_NONE   = 2'd0,
        LAMP_STEADY = 2'd1,
        LAMP_SLOW   = 2'd2,
        LAMP_FAST   = 2'd3
    } lamp_level_t;

    // One engine update
    typedef struct packed {
        logic        any_sensor_fault;
        logic [11:0] lambda_reading;
        logic [11:0] manifold_pressure;
        logic        position_valid;
        logic [31:0] window_end;
        logic [31:0] window_start;
        logic        rpm_valid;
        logic [31:0] now_ticks;
    } engine_item_t;

    // Lean detection limits
    typedef struct packed {
        logic [11:0] lean_pressure_limit;
        logic [11:0] lean_lambda_limit;
    } lean_cfg_t;

endpackage

>>> sv/fplc_state.sv
module fplc_state #(
    parameter int TICKS_PER_SECOND = fplc_pkg::TICKS_PER_SECOND_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    upd,
    input  fplc_pkg::engine_item_t  item,
    input  fplc_pkg::lean_cfg_t     cfg,
    output logic                    pump_on,
    output fplc_pkg::lamp_level_t   level,
    output logic [31:0]             lamp_elapsed
);

    localparam logic [63:0] HoldRaw  = (64'(TICKS_PER_SECOND) * 64'd4000000) / 64'd1000000;
    localparam logic [63:0] OffRaw   = (64'(TICKS_PER_SECOND) * 64'd5000000) / 64'd1000000;
    localparam logic [63:0] ClearRaw = (64'(TICKS_PER_SECOND) * 64'd3000000) / 64'd1000000;
    localparam logic [31:0] HoldTicks  = HoldRaw[31:0];
    localparam logic [31:0] OffTicks   = OffRaw[31:0];
    localparam logic [31:0] ClearTicks = ClearRaw[31:0];

    logic [31:0]           last_on_reg, last_on_next;
    logic [31:0]           since_reg, since_next;
    fplc_pkg::lamp_level_t level_reg, level_next;
    fplc_pkg::lamp_level_t want, level_live;
    logic                  in_win;

    // Decoder validity window, wrapping when end lies below start
    always_comb begin
        if (item.window_end >= item.window_start) begin
            in_win = (item.now_ticks >= item.window_start) &&
                     (item.now_ticks <= item.window_end);
        end else begin
            in_win = (item.now_ticks >= item.window_start) ||
                     (item.now_ticks <= item.window_end);
        end
    end

    // Pump hold
    always_comb begin
        last_on_next = last_on_reg;
        if (item.rpm_valid && in_win) begin
            last_on_next = item.now_ticks;
            pump_on      = 1'b1;
        end else if ((item.now_ticks - last_on_reg) < HoldTicks) begin
            pump_on      = 1'b1;
        end else begin
            last_on_next = item.now_ticks - OffTicks;
            pump_on      = 1'b0;
        end
    end

    // Lamp request by priority, expiry, then raise
    always_comb begin
        if ((item.manifold_pressure > cfg.lean_pressure_limit) &&
            (item.lambda_reading > cfg.lean_lambda_limit)) begin
            want = fplc_pkg::LAMP_FAST;
        end else if (!item.position_valid) begin
            want = fplc_pkg::LAMP_SLOW;
        end else if (item.any_sensor_fault) begin
            want = fplc_pkg::LAMP_STEADY;
        end else begin
            want = fplc_pkg::LAMP_NONE;
        end

        level_live = ((item.now_ticks - since_reg) > ClearTicks) ?
                     fplc_pkg::LAMP_NONE : level_reg;

        level_next = level_live;
        since_next = since_reg;
        if (want > level_live) begin
            level_next = want;
            since_next = item.now_ticks;
        end
    end

    assign level        = level_next;
    assign lamp_elapsed = item.now_ticks - since_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_on_reg <= '0;
            since_reg   <= '0;
            level_reg   <= fplc_pkg::LAMP_NONE;
        end else if (upd) begin
            last_on_reg <= last_on_next;
            since_reg   <= since_next;
            level_reg   <= level_next;
        end
    end

endmodule

>>> sv/fplc_blink_div.sv
module fplc_blink_div #(
    parameter int TICKS_PER_SECOND = fplc_pkg::TICKS_PER_SECOND_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           in_elapsed,
    input  fplc_pkg::lamp_level_t in_level,
    input  logic                  in_pump,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_pump,
    output logic                  out_lamp
);

    // Blink periods in ticks, at least one tick
    localparam logic [63:0] SlowRaw = (64'(TICKS_PER_SECOND) * 64'd500000) / 64'd1000000;
    localparam logic [63:0] FastRaw = (64'(TICKS_PER_SECOND) * 64'd200000) / 64'd1000000;
    localparam logic [31:0] SlowP = (SlowRaw == 64'd0) ? 32'd1 : SlowRaw[31:0];
    localparam logic [31:0] FastP = (FastRaw == 64'd0) ? 32'd1 : FastRaw[31:0];
    // Reciprocals floor(2^32 / p): the estimate is the quotient or one less
    localparam logic [63:0] SlowMRaw = (64'd1 << 32) / 64'(SlowP);
    localparam logic [63:0] FastMRaw = (64'd1 << 32) / 64'(FastP);
    localparam logic [32:0] SlowM = SlowMRaw[32:0];
    localparam logic [32:0] FastM = FastMRaw[32:0];
    localparam int Stages = 5;

    logic [Stages-1:0] valid_reg, valid_next;
    logic [Stages-1:0] take;

    // Stage payloads
    logic [31:0]           d_reg  [Stages-1];
    fplc_pkg::lamp_level_t lvl_reg[Stages-1];
    logic                  pmp_reg[Stages-1];
    logic [47:0]           pp_lo_reg;
    logic [48:0]           pp_hi_reg;
    logic [31:0]           q_est_reg;
    logic                  q_lsb_reg;
    logic [31:0]           prod_reg;
    logic                  pump_reg, lamp_reg;

    logic [32:0] m_sel;
    logic [31:0] p_sel3, p_sel4;
    logic [49:0] q_sum;
    logic [31:0] rem;
    logic        q_odd;
    logic        lamp_next;

    // Bubble-collapsing handshake along the stages
    always_comb begin
        take[Stages-1] = !valid_reg[Stages-1] || out_ready;
        for (int k = Stages - 2; k >= 0; k--) begin
            take[k] = !valid_reg[k] || take[k+1];
        end
        valid_next[0] = take[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < Stages; k++) begin
            if (take[k]) begin
                valid_next[k] = valid_reg[k-1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    assign in_ready  = take[0];
    assign out_valid = valid_reg[Stages-1];
    assign out_pump  = pump_reg;
    assign out_lamp  = lamp_reg;

    // Period and reciprocal selection
    assign m_sel  = (lvl_reg[0] == fplc_pkg::LAMP_FAST) ? FastM : SlowM;
    assign p_sel3 = (lvl_reg[2] == fplc_pkg::LAMP_FAST) ? FastP : SlowP;
    assign p_sel4 = (lvl_reg[3] == fplc_pkg::LAMP_FAST) ? FastP : SlowP;

    // Quotient estimate from the partial products
    assign q_sum = 50'(pp_hi_reg) + 50'(pp_lo_reg[47:16]);

    // Remainder correction, only the quotient's parity is kept
    assign rem   = d_reg[3] - prod_reg;
    assign q_odd = q_lsb_reg ^ (rem >= p_sel4);

    always_comb begin
        case (lvl_reg[3])
            fplc_pkg::LAMP_NONE:   lamp_next = 1'b0;
            fplc_pkg::LAMP_STEADY: lamp_next = 1'b1;
            default:               lamp_next = q_odd;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Stage registers, each loaded when its stage takes
    always_ff @(posedge aclk) begin
        // Stage 0: capture elapsed time and sideband
        if (take[0]) begin
            d_reg[0]   <= in_elapsed;
            lvl_reg[0] <= in_level;
            pmp_reg[0] <= in_pump;
        end

        // Stage 1: elapsed times reciprocal, two partial products
        if (take[1]) begin
            pp_lo_reg  <= 48'(d_reg[0]) * 48'(m_sel[15:0]);
            pp_hi_reg  <= 49'(d_reg[0]) * 49'(m_sel[32:16]);
            d_reg[1]   <= d_reg[0];
            lvl_reg[1] <= lvl_reg[0];
            pmp_reg[1] <= pmp_reg[0];
        end

        // Stage 2: sum partial products into the quotient estimate
        if (take[2]) begin
            q_est_reg  <= q_sum[47:16];
            d_reg[2]   <= d_reg[1];
            lvl_reg[2] <= lvl_reg[1];
            pmp_reg[2] <= pmp_reg[1];
        end

        // Stage 3: estimate times period, low word only
        if (take[3]) begin
            prod_reg   <= q_est_reg * p_sel3;
            q_lsb_reg  <= q_est_reg[0];
            d_reg[3]   <= d_reg[2];
            lvl_reg[3] <= lvl_reg[2];
            pmp_reg[3] <= pmp_reg[2];
        end

        // Stage 4: result register
        if (take[4]) begin
            pump_reg <= pmp_reg[3];
            lamp_reg <= lamp_next;
        end
    end

endmodule

>>> sv/fuel_pump_and_warning_lamp_control.sv
// Fuel pump and check-engine lamp control. Each engine update on the s_ stream
// gives one transfer on the m_ stream with the pump and lamp drive levels. The
// block takes one update per clock cycle sustained while the m_ stream does
// not stall. Each update passes the input register, the state update, then
// a reciprocal-multiply divider that finds the blink phase. Pump and lamp
// state live in one register set updated as each update leaves the input
// register, so back-to-back updates see each other's state. The user must
// write the two lean limits through the cfg_ port only while no update is in
// flight; the block itself does not enforce it.
module fuel_pump_and_warning_lamp_control #(
    parameter int TICKS_PER_SECOND = fplc_pkg::TICKS_PER_SECOND_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Engine updates
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_ticks[31:0], rpm_valid[32], window_start[64:33], window_end[96:65],
    // position_valid[97], manifold_pressure[109:98], lambda_reading[121:110],
    // any_sensor_fault[122], zero[127:123]
    input  logic [fplc_pkg::S_TDATA_W-1:0] s_tdata,
    // Drive levels
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pump_on[0], lamp_on[1], zero[7:2]
    output logic [fplc_pkg::M_TDATA_W-1:0] m_tdata,
    // Configuration writes
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [11:0]                    cfg_wdata
);

    fplc_pkg::lean_cfg_t    cfg_reg;
    fplc_pkg::engine_item_t item_reg;
    logic                   item_valid_reg;

    logic                   div_ready;
    logic                   upd;
    logic                   pump_on;
    fplc_pkg::lamp_level_t  level;
    logic [31:0]            lamp_elapsed;
    logic                   out_pump, out_lamp;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lean_pressure_limit <= fplc_pkg::LEAN_PRESSURE_RESET;
            cfg_reg.lean_lambda_limit   <= fplc_pkg::LEAN_LAMBDA_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fplc_pkg::CFG_LEAN_PRESSURE: cfg_reg.lean_pressure_limit <= cfg_wdata;
                fplc_pkg::CFG_LEAN_LAMBDA:   cfg_reg.lean_lambda_limit   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    assign upd      = item_valid_reg && div_ready;
    assign s_tready = !item_valid_reg || div_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            item_reg <= s_tdata[$bits(fplc_pkg::engine_item_t)-1:0];
        end
    end

    fplc_state #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_state (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd          (upd),
        .item         (item_reg),
        .cfg          (cfg_reg),
        .pump_on      (pump_on),
        .level        (level),
        .lamp_elapsed (lamp_elapsed)
    );

    fplc_blink_div #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_blink_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (item_valid_reg),
        .in_ready   (div_ready),
        .in_elapsed (lamp_elapsed),
        .in_level   (level),
        .in_pump    (pump_on),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pump   (out_pump),
        .out_lamp   (out_lamp)
    );

    assign m_tdata = {(fplc_pkg::M_TDATA_W - 2)'(0), out_lamp, out_pump};

endmodule

>>> sv/fplc_checker.sv
module fplc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fplc_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its data
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Padding above the two drive levels is zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[fplc_pkg::M_TDATA_W-1:2] == '0))
        else $error("result padding not zero");

    // With the output register empty nothing downstream can block input
    a_ready_when_empty: assert property (@(posedge aclk)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind fuel_pump_and_warning_lamp_control fplc_checker u_fplc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

>>> tb/tb_fuel_pump_and_warning_lamp_control.sv
`timescale 1ns / 100ps

module tb_fuel_pump_and_warning_lamp_control;

    localparam int TPS        = fplc_pkg::TICKS_PER_SECOND_DEFAULT;
    localparam int IDLE_LIMIT = 3000;   // cycles with no transfer before giving up
    localparam int DRAIN_WAIT = 20;
    localparam int PHASE_ITEMS = 250;

    // Drive levels expected for one update
    typedef struct {
        bit pump;
        bit lamp;
    } drive_t;

    // One row of the directed table
    typedef struct {
        fplc_pkg::engine_item_t item;
        bit                     typed;
        bit                     pump;
        bit                     lamp;
    } drive_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [127:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = fplc_pkg::CFG_LEAN_PRESSURE;
    logic [11:0] cfg_wdata = '0;

    // Predictor state and limits
    logic [31:0]           pr_pump_last_on;
    fplc_pkg::lamp_level_t pr_lamp_level;
    logic [31:0]           pr_lamp_since;
    logic [11:0]           pr_press_limit;
    logic [11:0]           pr_lambda_limit;

    drive_t      pending_drive[$];
    drive_row_t  dir_tab[$];
    int          err_cnt   = 0;
    int          idle_cnt  = 0;
    bit          calm      = 1'b0;   // sender offers back to back
    bit          hold_req  = 1'b0;   // receiver to hold off for a long stretch
    logic [31:0] sim_now;
    bit          running;

    fuel_pump_and_warning_lamp_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Microseconds to ticks, truncated
    function automatic logic [31:0] us_ticks(longint unsigned us);
        longint unsigned t;
        t = (us * longint'(TPS)) / 64'd1000000;
        return t[31:0];
    endfunction

    function automatic bit time_in_window(logic [31:0] now, logic [31:0] lo, logic [31:0] hi);
        if (hi >= lo)
            return (now >= lo) && (now <= hi);
        return (now >= lo) || (now <= hi);
    endfunction

    function automatic bit blink_phase(logic [31:0] now, logic [31:0] since,
                                       longint unsigned period_us);
        logic [31:0] p;
        logic [31:0] q;
        p = us_ticks(period_us);
        if (p == 0)
            p = 1;
        q = (now - since) / p;
        return q[0];
    endfunction

    // Advance the predicted pump and lamp state by one update
    function automatic drive_t pump_lamp_predict(fplc_pkg::engine_item_t it);
        drive_t                d;
        fplc_pkg::lamp_level_t want;
        logic [31:0]           now;
        now = it.now_ticks;

        // pump
        if (it.rpm_valid && time_in_window(now, it.window_start, it.window_end)) begin
            pr_pump_last_on = now;
            d.pump = 1'b1;
        end else if ((now - pr_pump_last_on) < us_ticks(4000000)) begin
            d.pump = 1'b1;
        end else begin
            pr_pump_last_on = now - us_ticks(5000000);
            d.pump = 1'b0;
        end

        // lamp request by priority
        if (it.manifold_pressure > pr_press_limit && it.lambda_reading > pr_lambda_limit)
            want = fplc_pkg::LAMP_FAST;
        else if (!it.position_valid)
            want = fplc_pkg::LAMP_SLOW;
        else if (it.any_sensor_fault)
            want = fplc_pkg::LAMP_STEADY;
        else
            want = fplc_pkg::LAMP_NONE;

        // expiry before the request
        if ((now - pr_lamp_since) > us_ticks(3000000))
            pr_lamp_level = fplc_pkg::LAMP_NONE;
        if (want > pr_lamp_level) begin
            pr_lamp_level = want;
            pr_lamp_since = now;
        end

        case (pr_lamp_level)
            fplc_pkg::LAMP_NONE:   d.lamp = 1'b0;
            fplc_pkg::LAMP_STEADY: d.lamp = 1'b1;
            fplc_pkg::LAMP_SLOW:   d.lamp = blink_phase(now, pr_lamp_since, 500000);
            default:               d.lamp = blink_phase(now, pr_lamp_since, 200000);
        endcase
        return d;
    endfunction

    function automatic fplc_pkg::engine_item_t mk_item(logic [31:0] now, bit rpm,
                                                       logic [31:0] ws, logic [31:0] we,
                                                       bit pos, logic [11:0] press,
                                                       logic [11:0] lam, bit fault);
        fplc_pkg::engine_item_t it;
        it.now_ticks         = now;
        it.rpm_valid         = rpm;
        it.window_start      = ws;
        it.window_end        = we;
        it.position_valid    = pos;
        it.manifold_pressure = press;
        it.lambda_reading    = lam;
        it.any_sensor_fault  = fault;
        return it;
    endfunction

    task automatic add_row(fplc_pkg::engine_item_t it, bit typed, bit pump, bit lamp);
        drive_row_t r;
        r.item  = it;
        r.typed = typed;
        r.pump  = pump;
        r.lamp  = lamp;
        dir_tab.push_back(r);
    endtask

    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
        err_cnt++;
    endtask

    // Offer one update; the expectation is taken at the transfer
    task automatic send_update(fplc_pkg::engine_item_t it, bit typed, bit pump, bit lamp);
        drive_t d;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it};
        do @(posedge aclk); while (!s_tready);
        d = pump_lamp_predict(it);
        if (typed) begin
            d.pump = pump;
            d.lamp = lamp;
        end
        pending_drive.push_back(d);
    endtask

    // Gap before the next offer: mostly short, a few long
    task automatic sender_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else if (r < 98)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 80);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (pending_drive.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limits(logic [11:0] press, logic [11:0] lam);
        cfg_wr_en <= 1'b1;
        cfg_index <= fplc_pkg::CFG_LEAN_PRESSURE;
        cfg_wdata <= press;
        @(posedge aclk);
        pr_press_limit = press;
        cfg_index <= fplc_pkg::CFG_LEAN_LAMBDA;
        cfg_wdata <= lam;
        @(posedge aclk);
        pr_lambda_limit = lam;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [11:0] near_limit(logic [11:0] lim);
        int v;
        v = int'(lim) + $urandom_range(0, 6) - 3;
        if (v < 0)
            v = 0;
        if (v > 4000)
            v = 4000;
        return v[11:0];
    endfunction

    // Engine-like update on a running clock, or now and then pure noise
    function automatic fplc_pkg::engine_item_t random_update();
        fplc_pkg::engine_item_t it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            it = mk_item($urandom, 1'($urandom_range(0, 1)), $urandom, $urandom,
                         1'($urandom_range(0, 1)), 12'($urandom_range(0, 4000)),
                         12'($urandom_range(0, 4000)), 1'($urandom_range(0, 1)));
            return it;
        end
        r = $urandom_range(0, 99);
        if (r < 75)
            sim_now += $urandom_range(0, 400000);
        else if (r < 97)
            sim_now += $urandom_range(400000, 6000000);
        else
            sim_now += $urandom_range(6000000, 20000000);
        if ($urandom_range(0, 99) < 4)
            running = !running;
        it = mk_item(sim_now, 1'b0, sim_now - $urandom_range(0, 100000),
                     sim_now + $urandom_range(0, 100000), 1'b1, 0, 0, 1'b0);
        if (running) begin
            it.rpm_valid = ($urandom_range(0, 99) < 95);
            r = $urandom_range(0, 99);
            if (r < 5)
                it.window_end = sim_now - $urandom_range(1, 1000);
            else if (r < 10)
                it.window_start = sim_now + $urandom_range(1, 1000);
        end else begin
            it.rpm_valid = ($urandom_range(0, 99) < 10);
        end
        it.position_valid   = ($urandom_range(0, 99) < 90);
        it.any_sensor_fault = ($urandom_range(0, 99) < 6);
        r = $urandom_range(0, 99);
        if (r < 70)
            it.manifold_pressure = 12'($urandom_range(0, pr_press_limit));
        else if (r < 85)
            it.manifold_pressure = near_limit(pr_press_limit);
        else
            it.manifold_pressure = 12'($urandom_range(0, 4000));
        r = $urandom_range(0, 99);
        if (r < 50)
            it.lambda_reading = near_limit(pr_lambda_limit);
        else
            it.lambda_reading = 12'($urandom_range(0, 4000));
        return it;
    endfunction

    // Result side: check each transfer, stall at random
    initial begin
        int stall;
        int r;
        drive_t d;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_drive.size() == 0) begin
                    report_mismatch("unexpected result, m_tdata", -1, int'(m_tdata));
                end else begin
                    d = pending_drive.pop_front();
                    if (m_tdata[0] !== d.pump)
                        report_mismatch("pump_on", int'(d.pump), int'(m_tdata[0]));
                    if (m_tdata[1] !== d.lamp)
                        report_mismatch("lamp_on", int'(d.lamp), int'(m_tdata[1]));
                end
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall = 300;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (calm || r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    if (r < 96)
                        stall = $urandom_range(0, 3);
                    else
                        stall = $urandom_range(10, 60);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("tb_fuel_pump_and_warning_lamp_control: errors");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        drive_row_t row;
        logic [11:0] lim_p[6];
        logic [11:0] lim_l[6];

        pr_pump_last_on = '0;
        pr_lamp_level   = fplc_pkg::LAMP_NONE;
        pr_lamp_since   = '0;
        pr_press_limit  = fplc_pkg::LEAN_PRESSURE_RESET;
        pr_lambda_limit = fplc_pkg::LEAN_LAMBDA_RESET;
        sim_now = $urandom;
        running = 1'b1;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, reset limits
        add_row(mk_item(0, 0, 0, 0, 1, 0, 0, 0), 1, 1, 0);              // after reset
        add_row(mk_item(100, 1, 50, 200, 1, 0, 0, 0), 1, 1, 0);
        add_row(mk_item(16000099, 0, 0, 0, 1, 0, 0, 0), 0, 0, 0);        // last hold tick
        add_row(mk_item(16000100, 0, 0, 0, 1, 0, 0, 0), 1, 0, 0);        // hold expires
        add_row(mk_item(32'hFFFF_FFF0, 1, 32'hFFFF_FF00, 32'h10, 1, 0, 0, 0), 0, 0, 0);
        add_row(mk_item(32'h5, 1, 32'hFFFF_FF00, 32'h10, 1, 0, 0, 0), 0, 0, 0);
        add_row(mk_item(32'h80, 1, 32'hFFFF_FF00, 32'h10, 1, 0, 0, 0), 0, 0, 0);
        add_row(mk_item(40000000, 1, 40000000, 40000000, 1, 0, 0, 1), 1, 1, 1); // fault
        add_row(mk_item(40000001, 1, 39000000, 41000000, 0, 0, 0, 0), 0, 0, 0); // loss
        add_row(mk_item(42000001, 0, 0, 0, 1, 0, 0, 0), 0, 0, 0);
        add_row(mk_item(42400000, 1, 42000000, 43000000, 1, 1501, 851, 0), 0, 0, 0);
        add_row(mk_item(43200000, 1, 42000000, 44000000, 1, 1500, 850, 0), 0, 0, 0);
        add_row(mk_item(54400000, 0, 0, 0, 1, 0, 0, 0), 0, 0, 0);        // exactly 3 s
        add_row(mk_item(54400001, 0, 0, 0, 1, 0, 0, 1), 0, 0, 0);        // expired, steady
        add_row(mk_item(54400002, 0, 0, 0, 1, 4000, 4000, 0), 0, 0, 0);
        add_row(mk_item(54400003, 0, 0, 0, 0, 0, 0, 1), 0, 0, 0);
        add_row(mk_item(32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF, 1, 4000, 0, 0), 1, 1, 0);
        add_row(mk_item(0, 1, 1, 0, 1, 0, 4000, 0), 0, 0, 0);
        add_row(mk_item(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 4000, 4000, 1),
                0, 0, 0);
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            sender_gap();
            send_update(row.item, row.typed, row.pump, row.lamp);
        end
        wait_drained();

        // Random phases over several limit settings, the first at reset values
        lim_p[0] = fplc_pkg::LEAN_PRESSURE_RESET; lim_l[0] = fplc_pkg::LEAN_LAMBDA_RESET;
        lim_p[1] = 12'd0;                         lim_l[1] = 12'd0;
        lim_p[2] = 12'd4000;                      lim_l[2] = 12'd4000;
        lim_p[3] = 12'($urandom_range(0, 4000));  lim_l[3] = 12'($urandom_range(0, 4000));
        lim_p[4] = 12'($urandom_range(0, 4000));  lim_l[4] = 12'($urandom_range(0, 4000));
        lim_p[5] = fplc_pkg::LEAN_PRESSURE_RESET; lim_l[5] = fplc_pkg::LEAN_LAMBDA_RESET;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0)
                set_limits(lim_p[ph], lim_l[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // fill the block while the receiver holds off
                if (ph == 1 && n == 0) begin
                    hold_req = 1'b1;
                    calm = 1'b1;
                end
                // sender pauses until every result is back
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                sender_gap();
                send_update(random_update(), 0, 0, 0);
            end
            calm = 1'b0;
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0 && pending_drive.size() == 0) begin
            $display("tb_fuel_pump_and_warning_lamp_control: clean");
        end else begin
            $display("tb_fuel_pump_and_warning_lamp_control: errors");
        end
        $finish;
    end

endmodule
